// File: rtl/core/lpbs_pkg.sv
// lpbs_pkg: shared types, constants and helpers of the led panel bit-plane scanner
// used by lpbs_frame_store and led_panel_bitplane_scanner; depends on nothing else
package lpbs_pkg;

  // fixed field widths
  localparam int FUNC_W     = 1;
  localparam int ROW_IN_W   = 5;
  localparam int COL_IN_W   = 6;
  localparam int RGB_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DELAY_W    = 8;
  localparam int PCOUNT_W   = 4;
  localparam int PLANE_W    = 3;
  localparam int HOLD_W     = 15;
  localparam int ROWADDR_W  = 4;

  // parameter defaults
  localparam int DEF_HALF_ROWS     = 16;
  localparam int DEF_PANEL_COLUMNS = 64;
  localparam int DEF_COLOR_BITS    = 8;

  // register reset values
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 8'd3;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 4'd8;

  // color channel positions in a pixel word
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;
  localparam int BLUE_LSB  = 0;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_ENABLE = 2'd0,
    REG_DELAY_UNIT  = 2'd1,
    REG_PLANE_COUNT = 2'd2
  } cfg_reg_t;

  // scan phases
  typedef enum logic [1:0] {
    PH_SHIFT   = 2'd0,
    PH_LATCH   = 2'd1,
    PH_UNLATCH = 2'd2,
    PH_DISPLAY = 2'd3
  } phase_t;

  // control pin levels (everything but color data)
  typedef struct packed {
    logic                 shift_clk;
    logic                 blank;
    logic                 latch;
    logic [ROWADDR_W-1:0] row_address;
  } ctl_pins_t;

  // one full result item
  typedef struct packed {
    logic                 shift_clk;
    logic                 red_top;
    logic                 green_top;
    logic                 blue_top;
    logic                 red_bottom;
    logic                 green_bottom;
    logic                 blue_bottom;
    logic                 blank;
    logic                 latch;
    logic [ROWADDR_W-1:0] row_address;
  } pins_t;

  // frame store access strobes
  typedef struct packed {
    logic wr_en;
    logic wr_bottom;
    logic rd_en;
  } mem_ctl_t;

  // plane bit of each channel, {blue, green, red}
  function automatic logic [2:0] plane_bits(input logic [RGB_W-1:0] rgb,
                                            input logic [PLANE_W-1:0] plane);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = rgb[RED_LSB +: 8];
    g = rgb[GREEN_LSB +: 8];
    b = rgb[BLUE_LSB +: 8];
    return {b[plane], g[plane], r[plane]};
  endfunction

endpackage

// File: rtl/core/led_panel_bitplane_scanner.sv
// led_panel_bitplane_scanner: bit-plane scan sequencer for a two-half rgb led panel
// depends on lpbs_pkg and lpbs_frame_store
//
//  channel  | handshake          | carries
//  ---------+--------------------+-----------------------------------------------
//  in_      | in_valid/in_ready  | func, pixel row, column and color
//  out_     | out_valid/out_ready| shift clock, six color bits, blank, latch, row
//  cfg_     | cfg_we             | cfg_index selects register, cfg_wdata is data
//
// one item per cycle while in_ready is high; a tick's pin levels pass the store read
// register and the read stage, then a 4-entry result queue, which reserves a slot
// for the item in the read stage; in_ready drops when the queue would overflow or
// the store is busy. after reset the store sweeps HALF_ROWS * 2^clog2(PANEL_COLUMNS)
// entries (1024 by default) to zero, in_ready low; config writes are taken meanwhile.
module led_panel_bitplane_scanner #(
  parameter int HALF_ROWS     = lpbs_pkg::DEF_HALF_ROWS,
  parameter int PANEL_COLUMNS = lpbs_pkg::DEF_PANEL_COLUMNS,
  parameter int COLOR_BITS    = lpbs_pkg::DEF_COLOR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [lpbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpbs_pkg::FUNC_W-1:0]     in_func,
  input  logic [lpbs_pkg::ROW_IN_W-1:0]   in_pix_row,
  input  logic [lpbs_pkg::COL_IN_W-1:0]   in_pix_col,
  input  logic [lpbs_pkg::RGB_W-1:0]      in_pix_rgb,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_shift_clk,
  output logic                            out_red_top,
  output logic                            out_green_top,
  output logic                            out_blue_top,
  output logic                            out_red_bottom,
  output logic                            out_green_bottom,
  output logic                            out_blue_bottom,
  output logic                            out_blank,
  output logic                            out_latch,
  output logic [lpbs_pkg::ROWADDR_W-1:0]  out_row_address
);
  import lpbs_pkg::*;

  localparam int ROW_W    = $clog2(HALF_ROWS);
  localparam int COL_W    = $clog2(PANEL_COLUMNS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = Q_PTR_W + 1;
  localparam int ROWX_W   = ROW_IN_W + 2;

  // configuration registers
  logic                scan_enable_r;
  logic [DELAY_W-1:0]  delay_unit_r;
  logic [PCOUNT_W-1:0] plane_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_enable_r <= 1'b0;
      delay_unit_r  <= DELAY_RESET;
      plane_count_r <= PCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_ENABLE: scan_enable_r <= cfg_wdata[0];
        REG_DELAY_UNIT:  delay_unit_r  <= cfg_wdata[DELAY_W-1:0];
        REG_PLANE_COUNT: plane_count_r <= cfg_wdata[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // scan state
  phase_t             phase_r, phase_nxt;
  logic               half_r, half_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  ctl_pins_t          ctl_r, ctl_nxt;

  // read stage and result queue
  logic               p1_valid_r;
  logic               p1_shift_r;
  logic [PLANE_W-1:0] p1_plane_r;
  ctl_pins_t          p1_ctl_r;
  logic [5:0]         data_r;
  pins_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] q_wr_ptr_r;
  logic [Q_PTR_W-1:0] q_rd_ptr_r;
  logic [Q_CNT_W-1:0] q_cnt_r;

  // frame store connection
  mem_ctl_t           mem_ctl;
  logic               mem_busy;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [RGB_W-1:0]   rd_top;
  logic [RGB_W-1:0]   rd_bot;

  logic               in_fire;
  logic               tick_go;
  logic               pix_go;

  // pixel address decode
  logic [ROWX_W-1:0]       row_x;
  logic [ROWX_W-1:0]       row_rel;
  logic                    row_bottom;
  logic                    pix_in_range;
  logic [COL_W+COL_IN_W-1:0] col_x;
  logic [ROW_W+ROWADDR_W-1:0] row_out_x;
  logic [PCOUNT_W-1:0]     eff_planes;
  logic                    plane_last;
  logic [HOLD_W-1:0]       hold_load;

  assign row_x        = {2'b00, in_pix_row};
  assign row_bottom   = row_x >= ROWX_W'(HALF_ROWS);
  assign row_rel      = row_bottom ? row_x - ROWX_W'(HALF_ROWS) : row_x;
  assign col_x        = {{COL_W{1'b0}}, in_pix_col};
  assign pix_in_range = (row_x < ROWX_W'(2 * HALF_ROWS))
                     && (col_x < (COL_W+COL_IN_W)'(PANEL_COLUMNS));
  assign wr_addr      = {row_rel[ROW_W-1:0], col_x[COL_W-1:0]};
  assign rd_addr      = {row_r, col_r};
  assign row_out_x    = {{ROWADDR_W{1'b0}}, row_r};

  // handshake: hold a queue slot for the item in the read stage
  assign in_ready = !mem_busy
                 && ((q_cnt_r + Q_CNT_W'(p1_valid_r)) < Q_CNT_W'(Q_DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign tick_go  = in_fire && (in_func == FUNC_TICK) && scan_enable_r;
  assign pix_go   = in_fire && (in_func == FUNC_PIXEL) && pix_in_range;

  // plane count clamp and display length
  always_comb begin
    if (plane_count_r == '0) begin
      eff_planes = PCOUNT_W'(1);
    end else if (plane_count_r > PCOUNT_W'(COLOR_BITS)) begin
      eff_planes = PCOUNT_W'(COLOR_BITS);
    end else begin
      eff_planes = plane_count_r;
    end
  end

  assign plane_last = ({1'b0, plane_r} + PCOUNT_W'(1)) >= eff_planes;
  assign hold_load  = {{(HOLD_W-DELAY_W){1'b0}}, delay_unit_r} << plane_r;

  // scan sequencer
  always_comb begin
    logic do_next;
    do_next   = 1'b0;
    phase_nxt = phase_r;
    half_nxt  = half_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    hold_nxt  = hold_r;
    ctl_nxt   = ctl_r;
    mem_ctl.rd_en     = 1'b0;
    mem_ctl.wr_en     = pix_go;
    mem_ctl.wr_bottom = row_bottom;
    if (tick_go) begin
      unique case (phase_r)
        PH_SHIFT: begin
          mem_ctl.rd_en     = 1'b1;
          ctl_nxt.shift_clk = half_r;
          if (!half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            if (col_r == COL_W'(PANEL_COLUMNS - 1)) begin
              col_nxt   = '0;
              phase_nxt = PH_LATCH;
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
          end
        end
        PH_LATCH: begin
          ctl_nxt.blank       = 1'b1;
          ctl_nxt.latch       = 1'b1;
          ctl_nxt.row_address = row_out_x[ROWADDR_W-1:0];
          phase_nxt           = PH_UNLATCH;
        end
        PH_UNLATCH: begin
          ctl_nxt.blank = 1'b0;
          ctl_nxt.latch = 1'b0;
          hold_nxt      = hold_load;
          if (delay_unit_r == '0) begin
            do_next = 1'b1;
          end else begin
            phase_nxt = PH_DISPLAY;
          end
        end
        PH_DISPLAY: begin
          if (hold_r != '0) begin
            hold_nxt = hold_r - HOLD_W'(1);
          end
          if (hold_r <= HOLD_W'(1)) begin
            do_next = 1'b1;
          end
        end
        default: phase_nxt = PH_SHIFT;
      endcase
      // end of plane: next plane or next row
      if (do_next) begin
        phase_nxt = PH_SHIFT;
        if (plane_last) begin
          plane_nxt = '0;
          if (row_r == ROW_W'(HALF_ROWS - 1)) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          plane_nxt = plane_r + PLANE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SHIFT;
      half_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
      hold_r  <= '0;
      ctl_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      hold_r  <= hold_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  lpbs_frame_store #(
    .HALF_ROWS     (HALF_ROWS),
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .ADDR_W        (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (in_pix_rgb),
    .rd_addr (rd_addr),
    .busy    (mem_busy),
    .rd_top  (rd_top),
    .rd_bot  (rd_bot)
  );

  // read stage: carries the tick while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= tick_go;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      p1_shift_r <= mem_ctl.rd_en;
      p1_plane_r <= plane_r;
      p1_ctl_r   <= ctl_nxt;
    end
  end

  // color bits: fresh on shift ticks, held otherwise
  logic [2:0] top_bits;
  logic [2:0] bot_bits;
  logic [5:0] data_cur;
  pins_t      p1_res;

  assign top_bits = plane_bits(rd_top, p1_plane_r);
  assign bot_bits = plane_bits(rd_bot, p1_plane_r);
  assign data_cur = p1_shift_r ? {bot_bits, top_bits} : data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (p1_valid_r) begin
      data_r <= data_cur;
    end
  end

  always_comb begin
    p1_res.shift_clk    = p1_ctl_r.shift_clk;
    p1_res.red_top      = data_cur[0];
    p1_res.green_top    = data_cur[1];
    p1_res.blue_top     = data_cur[2];
    p1_res.red_bottom   = data_cur[3];
    p1_res.green_bottom = data_cur[4];
    p1_res.blue_bottom  = data_cur[5];
    p1_res.blank        = p1_ctl_r.blank;
    p1_res.latch        = p1_ctl_r.latch;
    p1_res.row_address  = p1_ctl_r.row_address;
  end

  // result queue
  logic q_push;
  logic q_pop;

  assign q_push = p1_valid_r;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_ptr_r] <= p1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= '0;
      q_rd_ptr_r <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr_r <= q_wr_ptr_r + Q_PTR_W'(1);
      end
      if (q_pop) begin
        q_rd_ptr_r <= q_rd_ptr_r + Q_PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
    end
  end

  // result ports
  pins_t q_head;

  assign q_head           = q_mem[q_rd_ptr_r];
  assign out_valid        = q_cnt_r != '0;
  assign out_shift_clk    = q_head.shift_clk;
  assign out_red_top      = q_head.red_top;
  assign out_green_top    = q_head.green_top;
  assign out_blue_top     = q_head.blue_top;
  assign out_red_bottom   = q_head.red_bottom;
  assign out_green_bottom = q_head.green_bottom;
  assign out_blue_bottom  = q_head.blue_bottom;
  assign out_blank        = q_head.blank;
  assign out_latch        = q_head.latch;
  assign out_row_address  = q_head.row_address;

endmodule

// File: rtl/core/lpbs_frame_store.sv
// lpbs_frame_store: top and bottom half pixel memories with a clearing pass after reset
// depends on lpbs_pkg
module lpbs_frame_store #(
  parameter int HALF_ROWS     = lpbs_pkg::DEF_HALF_ROWS,
  parameter int PANEL_COLUMNS = lpbs_pkg::DEF_PANEL_COLUMNS,
  parameter int ADDR_W        = $clog2(HALF_ROWS) + $clog2(PANEL_COLUMNS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpbs_pkg::mem_ctl_t         ctl,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [lpbs_pkg::RGB_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic                       busy,
  output logic [lpbs_pkg::RGB_W-1:0] rd_top,
  output logic [lpbs_pkg::RGB_W-1:0] rd_bot
);
  import lpbs_pkg::*;

  localparam int COL_W = $clog2(PANEL_COLUMNS);
  localparam int DEPTH = HALF_ROWS * (2 ** COL_W);

  logic [RGB_W-1:0]  mem_top [DEPTH];
  logic [RGB_W-1:0]  mem_bot [DEPTH];
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [RGB_W-1:0]  rd_top_r;
  logic [RGB_W-1:0]  rd_bot_r;

  // clearing sweep, one entry of each half per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign busy = clr_active_r;

  // write port
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem_top[clr_addr_r] <= '0;
      mem_bot[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      if (ctl.wr_bottom) begin
        mem_bot[wr_addr] <= wr_data;
      end else begin
        mem_top[wr_addr] <= wr_data;
      end
    end
  end

  // registered read of both halves at the same column
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_top_r <= mem_top[rd_addr];
      rd_bot_r <= mem_bot[rd_addr];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_bot = rd_bot_r;

endmodule

// File: tb/tb_led_panel_bitplane_scanner.sv
// tb_led_panel_bitplane_scanner: self-checking bench for the led panel bit-plane scanner
// predicts every pin-level item from its own scan model; depends on lpbs_pkg and the rtl
module tb_led_panel_bitplane_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import lpbs_pkg::*;

  localparam int HALF     = DEF_HALF_ROWS;
  localparam int COLS     = DEF_PANEL_COLUMNS;
  localparam int MAX_BITS = DEF_COLOR_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_MAX = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // clock and dut inputs, all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic [FUNC_W-1:0] in_func = FUNC_PIXEL;
  logic [ROW_IN_W-1:0] in_pix_row = '0;
  logic [COL_IN_W-1:0] in_pix_col = '0;
  logic [RGB_W-1:0] in_pix_rgb = '0;
  logic out_ready = 1'b0;

  logic in_ready;
  logic out_valid;
  logic out_shift_clk;
  logic out_red_top;
  logic out_green_top;
  logic out_blue_top;
  logic out_red_bottom;
  logic out_green_bottom;
  logic out_blue_bottom;
  logic out_blank;
  logic out_latch;
  logic [ROWADDR_W-1:0] out_row_address;

  led_panel_bitplane_scanner uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_pix_row       (in_pix_row),
    .in_pix_col       (in_pix_col),
    .in_pix_rgb       (in_pix_rgb),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shift_clk    (out_shift_clk),
    .out_red_top      (out_red_top),
    .out_green_top    (out_green_top),
    .out_blue_top     (out_blue_top),
    .out_red_bottom   (out_red_bottom),
    .out_green_bottom (out_green_bottom),
    .out_blue_bottom  (out_blue_bottom),
    .out_blank        (out_blank),
    .out_latch        (out_latch),
    .out_row_address  (out_row_address)
  );

  // scan model state
  logic [RGB_W-1:0] pixel_mem [0:2*HALF*COLS-1];
  logic [6:0] col_cnt;
  logic clk_half;
  logic [3:0] scan_row_m;
  logic [PLANE_W-1:0] plane_idx;
  phase_t phase_m;
  logic [HOLD_W-1:0] hold_cnt;
  pins_t pins_now;
  logic en_reg;
  logic [DELAY_W-1:0] delay_reg;
  logic [PCOUNT_W-1:0] planes_reg;

  pins_t expected_pins [$];
  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_led_panel_bitplane_scanner: errors");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one plane bit per channel, {red, green, blue}
  function automatic logic [2:0] rgb_plane(input logic [RGB_W-1:0] rgb,
                                           input logic [PLANE_W-1:0] p);
    return {rgb[RED_LSB + p], rgb[GREEN_LSB + p], rgb[BLUE_LSB + p]};
  endfunction

  // end of a plane: next plane, or next row once the plane count is reached
  task automatic next_plane_m();
    int nplanes;
    phase_m = PH_SHIFT;
    if (planes_reg == 0) nplanes = 1;
    else if (planes_reg > MAX_BITS) nplanes = MAX_BITS;
    else nplanes = planes_reg;
    if (int'(plane_idx) + 1 >= nplanes) begin
      plane_idx = '0;
      scan_row_m = (int'(scan_row_m) + 1 >= HALF) ? 4'd0 : scan_row_m + 4'd1;
    end else begin
      plane_idx = plane_idx + 1'b1;
    end
  endtask

  // predicted pin levels for one accepted item
  task automatic predict_pins(input logic [FUNC_W-1:0] func, input logic [ROW_IN_W-1:0] row,
                              input logic [COL_IN_W-1:0] col, input logic [RGB_W-1:0] rgb);
    logic [RGB_W-1:0] top_px;
    logic [RGB_W-1:0] bot_px;
    if (func == FUNC_PIXEL) begin
      pixel_mem[{row, col}] = rgb;
      return;
    end
    if (!en_reg) return;
    case (phase_m)
      PH_SHIFT: begin
        top_px = pixel_mem[{1'b0, scan_row_m, col_cnt[5:0]}];
        bot_px = pixel_mem[{1'b1, scan_row_m, col_cnt[5:0]}];
        {pins_now.red_top, pins_now.green_top, pins_now.blue_top} = rgb_plane(top_px, plane_idx);
        {pins_now.red_bottom, pins_now.green_bottom, pins_now.blue_bottom} =
          rgb_plane(bot_px, plane_idx);
        if (!clk_half) begin
          pins_now.shift_clk = 1'b0;
          clk_half = 1'b1;
        end else begin
          pins_now.shift_clk = 1'b1;
          clk_half = 1'b0;
          if (int'(col_cnt) + 1 >= COLS) begin
            col_cnt = '0;
            phase_m = PH_LATCH;
          end else begin
            col_cnt = col_cnt + 7'd1;
          end
        end
      end
      PH_LATCH: begin
        pins_now.blank = 1'b1;
        pins_now.latch = 1'b1;
        pins_now.row_address = scan_row_m;
        phase_m = PH_UNLATCH;
      end
      PH_UNLATCH: begin
        pins_now.latch = 1'b0;
        pins_now.blank = 1'b0;
        hold_cnt = {{(HOLD_W-DELAY_W){1'b0}}, delay_reg} << plane_idx;
        if (hold_cnt == 0) next_plane_m();
        else phase_m = PH_DISPLAY;
      end
      default: begin
        if (hold_cnt != 0) hold_cnt = hold_cnt - 1'b1;
        if (hold_cnt == 0) next_plane_m();
      end
    endcase
    expected_pins.push_back(pins_now);
  endtask

  // result check, sampled mid-cycle where the handshake is settled
  always @(negedge clk) begin : result_check
    pins_t got;
    pins_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_shift_clk, out_red_top, out_green_top, out_blue_top, out_red_bottom,
              out_green_bottom, out_blue_bottom, out_blank, out_latch, out_row_address};
      if (expected_pins.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX) $display("unexpected item: %p", got);
      end else begin
        want = expected_pins.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // register write and model update, with cfg_we dropped again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SCAN_ENABLE: en_reg = val[0];
      REG_DELAY_UNIT:  delay_reg = val;
      REG_PLANE_COUNT: planes_reg = val[PCOUNT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // send one item, sometimes after a random gap
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ROW_IN_W-1:0] row,
                           input logic [COL_IN_W-1:0] col, input logic [RGB_W-1:0] rgb);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_pix_row <= row;
    in_pix_col <= col;
    in_pix_rgb <= rgb;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    predict_pins(func, row, col, rgb);
    @(posedge clk);
  endtask

  // random tick, or a pixel write aimed mostly at the rows being scanned
  task automatic send_random(input int tick_pct);
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] col;
    logic [RGB_W-1:0] rgb;
    col = COL_IN_W'($urandom_range(COLS - 1));
    rgb = RGB_W'($urandom);
    if ($urandom_range(99) < 70) row = {1'($urandom_range(1)), scan_row_m};
    else row = ROW_IN_W'($urandom_range(2 * HALF - 1));
    if ($urandom_range(99) < tick_pct) send_item(FUNC_TICK, row, col, rgb);
    else send_item(FUNC_PIXEL, row, col, rgb);
  endtask

  // stop sending, wait for every expected item and the pipeline to empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes, disabled ticks, register masking and the unused index
  task automatic test_directed();
    send_item(FUNC_TICK, 5'd31, 6'd63, 24'hFFFFFF);
    send_item(FUNC_TICK, 5'd0, 6'd0, 24'h000000);
    send_item(FUNC_PIXEL, 5'd0, 6'd0, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 5'd16, 6'd0, 24'hFF0000);
    send_item(FUNC_PIXEL, 5'd0, 6'd1, 24'h00FF00);
    send_item(FUNC_PIXEL, 5'd16, 6'd1, 24'h0000FF);
    send_item(FUNC_PIXEL, 5'd15, 6'd63, 24'hA5A5A5);
    send_item(FUNC_PIXEL, 5'd31, 6'd63, 24'h5A5A5A);
    send_item(FUNC_PIXEL, 5'd31, 6'd0, 24'hFFFFFF);
    drain_pipeline();
    write_reg(REG_SCAN_ENABLE, 8'h01);
    repeat (10) send_item(FUNC_TICK, 5'd0, 6'd0, 24'h000000);
    drain_pipeline();
    write_reg(REG_UNUSED, 8'hFF);
    // only bit zero enables the scan
    write_reg(REG_SCAN_ENABLE, 8'hFE);
    repeat (2) send_item(FUNC_TICK, 5'd31, 6'd63, 24'hFFFFFF);
    drain_pipeline();
    write_reg(REG_SCAN_ENABLE, 8'hFF);
    write_reg(REG_DELAY_UNIT, 8'h00);
    // upper bits dropped, count zero acts as one plane
    write_reg(REG_PLANE_COUNT, 8'hF0);
    repeat (3) send_item(FUNC_TICK, 5'd0, 6'd0, 24'h000000);
  endtask

  // every plane of a two-plane row and the step to the next row, short display times
  task automatic test_plane_walk();
    logic [3:0] start_row;
    drain_pipeline();
    write_reg(REG_SCAN_ENABLE, 8'h01);
    write_reg(REG_DELAY_UNIT, 8'd1);
    write_reg(REG_PLANE_COUNT, 8'd2);
    start_row = scan_row_m;
    while (scan_row_m == start_row) send_random(85);
  endtask

  // random settings changed mid-scan, random items between
  task automatic test_random_settings(input int phases, input int items);
    logic [PCOUNT_W-1:0] pc;
    for (int p = 0; p < phases; p++) begin
      drain_pipeline();
      case ($urandom_range(5))
        0: pc = 4'd0;
        1: pc = 4'd1;
        2: pc = 4'd8;
        3: pc = 4'd9;
        4: pc = 4'd15;
        default: pc = PCOUNT_W'($urandom);
      endcase
      if ($urandom_range(1)) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      write_reg(REG_DELAY_UNIT, (p == 0) ? 8'd0 : CFG_DATA_W'($urandom_range(4)));
      write_reg(REG_PLANE_COUNT, {4'($urandom), pc});
      write_reg(REG_SCAN_ENABLE, {7'($urandom), 1'($urandom_range(9) != 0)});
      repeat (items) send_random(75);
    end
  endtask

  // widest display time on the lowest plane, into the display phase
  task automatic test_long_display();
    drain_pipeline();
    write_reg(REG_SCAN_ENABLE, 8'h01);
    write_reg(REG_DELAY_UNIT, 8'd255);
    write_reg(REG_PLANE_COUNT, 8'd1);
    while (phase_m != PH_DISPLAY) send_random(90);
    repeat (20) send_random(90);
  endtask

  // test sequence
  initial begin
    for (int i = 0; i < 2 * HALF * COLS; i++) pixel_mem[i] = '0;
    col_cnt = '0;
    clk_half = 1'b0;
    scan_row_m = '0;
    plane_idx = '0;
    phase_m = PH_SHIFT;
    hold_cnt = '0;
    pins_now = '0;
    en_reg = 1'b0;
    delay_reg = DELAY_RESET;
    planes_reg = PCOUNT_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 74;
    test_directed();
    test_plane_walk();
    test_long_display();

    send_idle_pct = 74;
    recv_idle_pct = 11;
    test_random_settings(3, 15);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings(3, 15);

    drain_pipeline();
    if (expected_pins.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("tb_led_panel_bitplane_scanner: clean");
    end else begin
      $display("tb_led_panel_bitplane_scanner: errors");
    end
    $finish;
  end

endmodule
